[rtl/core/glp_pkg.sv]
package glp_pkg;

    typedef enum logic [2:0] {
        W_NONE = 3'd0,
        W_F    = 3'd1,
        W_G    = 3'd2,
        W_M    = 3'd3,
        W_X    = 3'd4,
        W_Y    = 3'd5,
        W_Z    = 3'd6
    } word_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CASE_BIT = 8'h20;

    // classified character handed from the front to the back
    typedef struct packed {
        logic       has_char;
        logic       first;
        logic       slash;
        logic       pct;
        logic [7:0] ch;
        logic       line_last;
    } tok_t;

    typedef struct packed {
        logic        block_delete;
        logic        percent_line;
        logic [15:0] gcode_number;
        logic [15:0] mcode_number;
        logic [31:0] feed_milli;
        logic [31:0] x_milli;
        logic [31:0] y_milli;
        logic [31:0] z_milli;
    } res_t;

    function automatic word_t letter_word(input logic [7:0] c);
        logic [7:0] u;
        word_t      w;
        u = (c >= 8'h61 && c <= 8'h7A) ? (c - CASE_BIT) : c;
        case (u)
            8'h46:   w = W_F;
            8'h47:   w = W_G;
            8'h4D:   w = W_M;
            8'h58:   w = W_X;
            8'h59:   w = W_Y;
            8'h5A:   w = W_Z;
            default: w = W_NONE;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/glp_if.sv]
interface glp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       line_last;
    modport source (output valid, output ch, output line_last, input ready);
    modport sink (input valid, input ch, input line_last, output ready);
endinterface

interface glp_out_if;
    logic               valid;
    logic               ready;
    logic               block_delete;
    logic               percent_line;
    logic signed [15:0] gcode_number;
    logic signed [15:0] mcode_number;
    logic signed [31:0] feed_milli;
    logic signed [31:0] x_milli;
    logic signed [31:0] y_milli;
    logic signed [31:0] z_milli;
    modport source (output valid, output block_delete, output percent_line,
                    output gcode_number, output mcode_number, output feed_milli,
                    output x_milli, output y_milli, output z_milli, input ready);
    modport sink (input valid, input block_delete, input percent_line,
                  input gcode_number, input mcode_number, input feed_milli,
                  input x_milli, input y_milli, input z_milli, output ready);
endinterface

[rtl/core/gcode_line_parser.sv]
// channel | dir | payload
// in      | in  | ch, line_last
// out     | out | block_delete, percent_line, gcode/mcode_number, feed/x/y/z_milli
// One item a cycle while the output keeps up: front classifies in one registered
// step, a four-entry queue, then the back takes one item a cycle while no result waits.
// Result is registered; valid rises at the edge at which the back takes the line's last item.
// rst_n clears all control state and the modal values; no clearing pass.
// Either side stalls on its own; the queue absorbs short output stalls.
module gcode_line_parser #(
    parameter int LINE_LIMIT  = 256,
    parameter int FRAC_DIGITS = 3,
    parameter int COORD_BITS  = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    glp_in_if.sink     in,
    glp_out_if.source  out
);
    logic          f_valid, f_ready, q_valid, q_ready;
    glp_pkg::tok_t f_tok, q_tok;
    glp_pkg::res_t r;

    glp_front #(.LINE_LIMIT(LINE_LIMIT)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in.valid), .in_ready(in.ready),
        .in_ch(in.ch), .in_last(in.line_last),
        .tok_valid(f_valid), .tok_ready(f_ready), .tok(f_tok)
    );

    glp_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_tok),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_tok)
    );

    glp_back #(.FRAC_DIGITS(FRAC_DIGITS), .COORD_BITS(COORD_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .tok_valid(q_valid), .tok_ready(q_ready), .tok(q_tok),
        .res_valid(out.valid), .res_ready(out.ready), .res(r)
    );

    assign out.block_delete = r.block_delete;
    assign out.percent_line = r.percent_line;
    assign out.gcode_number = r.gcode_number;
    assign out.mcode_number = r.mcode_number;
    assign out.feed_milli   = r.feed_milli;
    assign out.x_milli      = r.x_milli;
    assign out.y_milli      = r.y_milli;
    assign out.z_milli      = r.z_milli;
endmodule

[rtl/core/glp_front.sv]
module glp_front #(
    parameter int LINE_LIMIT = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_ch,
    input  logic                in_last,
    output logic                tok_valid,
    input  logic                tok_ready,
    output glp_pkg::tok_t       tok
);
    localparam int CW = $clog2(LINE_LIMIT);

    logic [CW-1:0] count_reg;
    logic          stopped_reg, paren_reg, semi_reg, first_reg;
    logic          valid_reg;
    glp_pkg::tok_t tok_reg;

    logic          take;
    logic          live, stop_now, paren_n, semi_n, kept;
    glp_pkg::tok_t t;

    assign in_ready  = !valid_reg || tok_ready;
    assign take      = in_valid && in_ready;
    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

    always_comb
    begin
        live     = (in_ch != glp_pkg::CH_NUL) && !stopped_reg;
        stop_now = live && (in_ch == glp_pkg::CH_LF || in_ch == glp_pkg::CH_CR
                   || {1'b0, count_reg} >= (CW + 1)'(LINE_LIMIT - 1));
        paren_n  = paren_reg;
        semi_n   = semi_reg;
        kept     = 1'b0;
        if (live && !stop_now)
        begin
            if (!semi_n && in_ch == glp_pkg::CH_LPAR)
                paren_n = 1'b1;
            if (!paren_n && in_ch == glp_pkg::CH_SEMI)
                semi_n = 1'b1;
            if (paren_n || semi_n)
            begin
                if (in_ch == glp_pkg::CH_RPAR)
                begin
                    paren_n = 1'b0;
                    semi_n  = 1'b0;
                end
            end
            else if (in_ch != glp_pkg::CH_RPAR && in_ch != glp_pkg::CH_SPACE
                     && in_ch != glp_pkg::CH_TAB)
                kept = 1'b1;
        end
        t.has_char  = kept;
        t.first     = kept && !first_reg;
        t.slash     = in_ch == glp_pkg::CH_SLASH;
        t.pct       = in_ch == glp_pkg::CH_PCT;
        t.ch        = in_ch;
        t.line_last = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            stopped_reg <= 1'b0;
            paren_reg   <= 1'b0;
            semi_reg    <= 1'b0;
            first_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (tok_ready)
                valid_reg <= 1'b0;
            if (take)
            begin
                valid_reg <= 1'b1;
                tok_reg   <= t;
                if (in_last)
                begin
                    count_reg   <= '0;
                    stopped_reg <= 1'b0;
                    paren_reg   <= 1'b0;
                    semi_reg    <= 1'b0;
                    first_reg   <= 1'b0;
                end
                else
                begin
                    if (stop_now)
                        stopped_reg <= 1'b1;
                    if (live && !stop_now)
                        count_reg <= count_reg + 1'b1;
                    paren_reg <= paren_n;
                    semi_reg  <= semi_n;
                    if (kept)
                        first_reg <= 1'b1;
                end
            end
        end
    end
endmodule

[rtl/core/glp_fifo.sv]
module glp_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  glp_pkg::tok_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output glp_pkg::tok_t rd_data
);
    glp_pkg::tok_t mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = cnt_reg != 3'd4;
    assign rd_valid = cnt_reg != 3'd0;
    assign rd_data  = mem[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {2'b0, wr} - {2'b0, rd};
        end
    end
endmodule

[rtl/core/glp_back.sv]
module glp_back #(
    parameter int FRAC_DIGITS = 3,
    parameter int COORD_BITS  = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tok_valid,
    output logic          tok_ready,
    input  glp_pkg::tok_t tok,
    output logic          res_valid,
    input  logic          res_ready,
    output glp_pkg::res_t res
);
    localparam int AW = COORD_BITS + 1;
    localparam logic [AW-1:0] CAP = {2'b0, {(COORD_BITS - 1){1'b1}}};
    localparam logic [AW-1:0] ICAP = AW'(32768);
    localparam logic [AW-1:0] CAP10 = CAP / 10;
    localparam logic [AW-1:0] CAP100 = CAP / 100;
    localparam logic [AW-1:0] CAP1000 = CAP / 1000;
    localparam logic [AW-1:0] ICAP10 = AW'(32768 / 10);
    localparam logic [3:0]    CAP_REM = 4'(CAP % 10);
    localparam logic [3:0]    ICAP_REM = 4'(32768 % 10);

    logic          slash_reg, pct_reg, neg_reg, sign_ok_reg, dot_reg;
    logic [1:0]    frac_reg;
    logic [AW-1:0] acc_reg;
    glp_pkg::word_t word_reg;
    logic [15:0]   g_reg, m_reg;
    logic [COORD_BITS-1:0] f_reg, x_reg, y_reg, z_reg;
    logic          rv_reg;
    glp_pkg::res_t res_reg;

    logic          take, integ, digit, do_commit, open_new;
    logic [3:0]    d;
    logic [AW-1:0] mac_cap, mac, scaled;
    logic [15:0]   iv;
    logic [COORD_BITS-1:0] cv;
    glp_pkg::word_t lw;
    logic          acc_upd, neg_upd, frac_upd, dot_set, sign_clr;
    logic [15:0]   g_n, m_n;
    logic [COORD_BITS-1:0] f_n, x_n, y_n, z_n;

    assign tok_ready = !rv_reg || res_ready;
    assign take      = tok_valid && tok_ready;
    assign res_valid = rv_reg;
    assign res       = res_reg;

    function automatic logic [AW-1:0] mul10(input logic [AW-1:0] a);
        return (a << 3) + (a << 1);
    endfunction

    // scale to thousandths for missing fraction digits, saturated
    function automatic logic [AW-1:0] pad(input logic [AW-1:0] a, input logic [1:0] fd);
        logic [AW-1:0] v;
        case (fd)
            2'd0:    v = (a > CAP1000) ? CAP : (a << 10) - (a << 4) - (a << 3);
            2'd1:    v = (a > CAP100) ? CAP : (a << 6) + (a << 5) + (a << 2);
            2'd2:    v = (a > CAP10) ? CAP : mul10(a);
            default: v = a;
        endcase
        return v;
    endfunction

    always_comb
    begin
        integ    = word_reg == glp_pkg::W_G || word_reg == glp_pkg::W_M;
        digit    = tok.ch >= glp_pkg::CH_ZERO && tok.ch <= glp_pkg::CH_NINE;
        d        = tok.ch[3:0];
        mac_cap  = integ ? ICAP : CAP;
        if (acc_reg > mac_cap || acc_reg > ((integ ? ICAP10 : CAP10) -
            ((integ ? ICAP_REM : CAP_REM) < d ? AW'(1) : AW'(0))))
            mac = mac_cap;
        else
            mac = mul10(acc_reg) + AW'(d);
        lw        = glp_pkg::letter_word(tok.ch);
        do_commit = 1'b0;
        open_new  = 1'b0;
        acc_upd   = 1'b0;
        neg_upd   = 1'b0;
        frac_upd  = 1'b0;
        dot_set   = 1'b0;
        sign_clr  = 1'b0;
        if (tok.has_char && !(tok.first ? (tok.slash || tok.pct) : (slash_reg || pct_reg)))
        begin
            if (word_reg != glp_pkg::W_NONE)
            begin
                if (sign_ok_reg && (tok.ch == glp_pkg::CH_PLUS ||
                    tok.ch == glp_pkg::CH_MINUS))
                begin
                    neg_upd  = 1'b1;
                    sign_clr = 1'b1;
                end
                else if (digit)
                begin
                    sign_clr = 1'b1;
                    if (integ || !dot_reg)
                        acc_upd = 1'b1;
                    else if (int'(frac_reg) < FRAC_DIGITS)
                    begin
                        acc_upd  = 1'b1;
                        frac_upd = 1'b1;
                    end
                end
                else if (!integ && tok.ch == glp_pkg::CH_DOT)
                begin
                    sign_clr = 1'b1;
                    if (!dot_reg)
                        dot_set = 1'b1;
                    else
                        do_commit = 1'b1;
                end
                else
                begin
                    do_commit = 1'b1;
                    open_new  = lw != glp_pkg::W_NONE;
                end
            end
            else
                open_new = lw != glp_pkg::W_NONE;
        end
        if (tok.line_last && word_reg != glp_pkg::W_NONE && !open_new)
            do_commit = 1'b1;
        if (tok.line_last && open_new)
            do_commit = 1'b0;

        if (neg_reg)
            iv = (acc_reg >= ICAP) ? 16'h8000 : 16'(-acc_reg);
        else
            iv = (acc_reg >= ICAP - 1'b1) ? 16'h7FFF : 16'(acc_reg);
        scaled = pad(acc_reg, frac_reg);
        if (scaled > CAP)
            scaled = CAP;
        cv = neg_reg ? COORD_BITS'(-scaled) : COORD_BITS'(scaled);

        g_n = g_reg;
        m_n = m_reg;
        f_n = f_reg;
        x_n = x_reg;
        y_n = y_reg;
        z_n = z_reg;
        if (do_commit)
        begin
            case (word_reg)
                glp_pkg::W_G: g_n = iv;
                glp_pkg::W_M: m_n = iv;
                glp_pkg::W_F: f_n = cv;
                glp_pkg::W_X: x_n = cv;
                glp_pkg::W_Y: y_n = cv;
                glp_pkg::W_Z: z_n = cv;
                default: ;
            endcase
        end
        // a word opened by the last item commits as zero
        if (tok.line_last && open_new)
        begin
            case (lw)
                glp_pkg::W_G: g_n = '0;
                glp_pkg::W_M: m_n = '0;
                glp_pkg::W_F: f_n = '0;
                glp_pkg::W_X: x_n = '0;
                glp_pkg::W_Y: y_n = '0;
                glp_pkg::W_Z: z_n = '0;
                default: ;
            endcase
            if (word_reg != glp_pkg::W_NONE)
            begin
                case (word_reg)
                    glp_pkg::W_G: if (lw != glp_pkg::W_G) g_n = iv;
                    glp_pkg::W_M: if (lw != glp_pkg::W_M) m_n = iv;
                    glp_pkg::W_F: if (lw != glp_pkg::W_F) f_n = cv;
                    glp_pkg::W_X: if (lw != glp_pkg::W_X) x_n = cv;
                    glp_pkg::W_Y: if (lw != glp_pkg::W_Y) y_n = cv;
                    glp_pkg::W_Z: if (lw != glp_pkg::W_Z) z_n = cv;
                    default: ;
                endcase
            end
        end
    end

    // the accumulator on last-item digits must reach the commit too
    logic [AW-1:0] acc_eff;
    logic [1:0]    frac_eff;
    logic          neg_eff;
    logic [15:0]   iv_l;
    logic [AW-1:0] sc_l;
    logic [COORD_BITS-1:0] cv_l;

    always_comb
    begin
        acc_eff  = acc_upd ? mac : acc_reg;
        frac_eff = frac_upd ? frac_reg + 1'b1 : frac_reg;
        neg_eff  = neg_upd ? (tok.ch == glp_pkg::CH_MINUS) : neg_reg;
        if (neg_eff)
            iv_l = (acc_eff >= ICAP) ? 16'h8000 : 16'(-acc_eff);
        else
            iv_l = (acc_eff >= ICAP - 1'b1) ? 16'h7FFF : 16'(acc_eff);
        sc_l = pad(acc_eff, frac_eff);
        if (sc_l > CAP)
            sc_l = CAP;
        cv_l = neg_eff ? COORD_BITS'(-sc_l) : COORD_BITS'(sc_l);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slash_reg   <= 1'b0;
            pct_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            sign_ok_reg <= 1'b0;
            dot_reg     <= 1'b0;
            frac_reg    <= '0;
            acc_reg     <= '0;
            word_reg    <= glp_pkg::W_NONE;
            g_reg       <= '1;
            m_reg       <= '1;
            f_reg       <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            z_reg       <= '0;
            rv_reg      <= 1'b0;
        end
        else
        begin
            if (res_ready)
                rv_reg <= 1'b0;
            if (take)
            begin
                if (tok.line_last)
                begin
                    logic [15:0] gg, mm;
                    logic [COORD_BITS-1:0] ff, xx, yy, zz;
                    gg = g_n;
                    mm = m_n;
                    ff = f_n;
                    xx = x_n;
                    yy = y_n;
                    zz = z_n;
                    if (do_commit && !open_new)
                    begin
                        case (word_reg)
                            glp_pkg::W_G: gg = iv_l;
                            glp_pkg::W_M: mm = iv_l;
                            glp_pkg::W_F: ff = cv_l;
                            glp_pkg::W_X: xx = cv_l;
                            glp_pkg::W_Y: yy = cv_l;
                            glp_pkg::W_Z: zz = cv_l;
                            default: ;
                        endcase
                    end
                    rv_reg <= 1'b1;
                    res_reg.block_delete <= tok.first ? tok.slash : slash_reg;
                    res_reg.percent_line <= tok.first ? tok.pct : pct_reg;
                    res_reg.gcode_number <= gg;
                    res_reg.mcode_number <= mm;
                    res_reg.feed_milli   <= 32'($signed(ff));
                    res_reg.x_milli      <= 32'($signed(xx));
                    res_reg.y_milli      <= 32'($signed(yy));
                    res_reg.z_milli      <= 32'($signed(zz));
                    f_reg       <= ff;
                    x_reg       <= xx;
                    y_reg       <= yy;
                    z_reg       <= zz;
                    slash_reg   <= 1'b0;
                    pct_reg     <= 1'b0;
                    neg_reg     <= 1'b0;
                    sign_ok_reg <= 1'b0;
                    dot_reg     <= 1'b0;
                    frac_reg    <= '0;
                    acc_reg     <= '0;
                    word_reg    <= glp_pkg::W_NONE;
                    g_reg       <= '1;
                    m_reg       <= '1;
                end
                else
                begin
                    if (tok.first)
                    begin
                        slash_reg <= tok.slash;
                        pct_reg   <= tok.pct;
                    end
                    g_reg <= g_n;
                    m_reg <= m_n;
                    f_reg <= f_n;
                    x_reg <= x_n;
                    y_reg <= y_n;
                    z_reg <= z_n;
                    if (do_commit)
                        word_reg <= glp_pkg::W_NONE;
                    if (open_new)
                    begin
                        word_reg    <= lw;
                        sign_ok_reg <= 1'b1;
                        neg_reg     <= 1'b0;
                        acc_reg     <= '0;
                        dot_reg     <= 1'b0;
                        frac_reg    <= '0;
                    end
                    else
                    begin
                        if (sign_clr)
                            sign_ok_reg <= 1'b0;
                        if (neg_upd)
                            neg_reg <= tok.ch == glp_pkg::CH_MINUS;
                        if (acc_upd)
                            acc_reg <= mac;
                        if (frac_upd)
                            frac_reg <= frac_reg + 1'b1;
                        if (dot_set)
                            dot_reg <= 1'b1;
                    end
                end
            end
        end
    end
endmodule
